@@ rtl/pvs_pkg.sv @@
`default_nettype none

package pvs_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int SMP_W    = 12;
    localparam int LVL_IO_W = 12;
    localparam int HOLD_W   = 16;
    localparam int SUM_W    = 16;
    localparam int CLIMB_W  = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAIR_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_AMP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_HOLD    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_HOLD     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SEL  = 3'd7;

    // register reset values
    localparam logic [LVL_IO_W-1:0] RST_START_LEVEL = 12'd1472;
    localparam logic [LVL_IO_W-1:0] RST_END_LEVEL   = 12'd2751;
    localparam logic [LVL_IO_W-1:0] RST_STAIR_STEP  = 12'd6;
    localparam logic [LVL_IO_W-1:0] RST_PULSE_AMP   = 12'd38;
    localparam logic [HOLD_W-1:0]   RST_HOLD_MS     = 16'd98;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_START,
        OP_TICK,
        OP_SAMPLE,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SMP_W-1:0]  sample;
    } t_item;

    typedef struct packed {
        logic [LVL_IO_W-1:0] start_level;
        logic [LVL_IO_W-1:0] end_level;
        logic [LVL_IO_W-1:0] stair_step;
        logic [LVL_IO_W-1:0] pulse_height;
        logic [HOLD_W-1:0]   base_hold_ms;
        logic [HOLD_W-1:0]   high_hold_ms;
        logic [HOLD_W-1:0]   low_hold_ms;
        logic                channel_select;
    } t_cfg;

    typedef struct packed {
        logic [LVL_IO_W-1:0] dac_level;
        logic                channel;
        logic                busy_res;
        logic                sample_request;
        logic                pair_valid;
        logic [SMP_W-1:0]    high_reading;
        logic [SMP_W-1:0]    low_reading;
        logic                last_pair;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/pvs_front.sv @@
`default_nettype none

module pvs_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire [pvs_pkg::CMD_W-1:0]  i_cmd,
    input  wire [pvs_pkg::SMP_W-1:0]  i_sample_value,
    output logic                      o_in_stall,
    output logic                      o_item_valid,
    output pvs_pkg::t_item            o_item,
    input  wire                       i_item_pop
);
    import pvs_pkg::*;

    t_item           r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    t_item cls_item;
    logic  push;
    logic  pop;

    // classify the command, samples carry their value only when they matter
    always_comb begin
        cls_item.sample = '0;
        unique case (i_cmd)
            CMD_START: cls_item.op = OP_START;
            CMD_TICK:  cls_item.op = OP_TICK;
            CMD_SAMPLE: begin
                cls_item.op     = OP_SAMPLE;
                cls_item.sample = i_sample_value;
            end
            default:   cls_item.op = OP_NONE;
        endcase
    end

    assign o_in_stall   = (r_count == Q_CW'(Q_DEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_q[r_wr_ptr] <= cls_item;
                r_wr_ptr      <= r_wr_ptr + Q_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/pvs_back.sv @@
`default_nettype none

module pvs_back #(
    parameter int SAMPLES_PER_POINT = 10,
    parameter int LEVEL_MAX         = 4095
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  pvs_pkg::t_cfg    i_cfg,
    input  wire              i_item_valid,
    input  pvs_pkg::t_item   i_item,
    output logic             o_item_pop,
    input  wire              i_out_stall,
    output logic             o_out_valid,
    output pvs_pkg::t_result o_res
);
    import pvs_pkg::*;

    localparam int LVL_W = ($clog2(LEVEL_MAX + 1) > LVL_IO_W) ?
                           $clog2(LEVEL_MAX + 1) : LVL_IO_W;
    localparam int CNT_W = $clog2(SAMPLES_PER_POINT + 1);
    // exact divide by the sample count: multiply by a rounded-up reciprocal
    localparam int REC_SHIFT = SUM_W + CNT_W;
    localparam int REC_W     = REC_SHIFT + 1;
    localparam int PROD_W    = SUM_W + REC_W;
    localparam logic [REC_W-1:0] REC_MUL =
        REC_W'(((64'd1 << REC_SHIFT) + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT);
    localparam logic [LVL_W+1:0] LVL_CAP = (LVL_W + 2)'(LEVEL_MAX);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BASE,
        PH_HOLD,
        PH_SAMPLE
    } t_phase;

    t_phase              r_phase,   n_phase;
    logic [LVL_W-1:0]    r_drive,   n_drive;
    logic [HOLD_W-1:0]   r_hold,    n_hold;
    logic [CNT_W-1:0]    r_cnt,     n_cnt;
    logic [SUM_W-1:0]    r_sum,     n_sum;
    logic [SMP_W-1:0]    r_held_hi, n_held_hi;
    logic [CLIMB_W-1:0]  r_climb,   n_climb;
    logic                r_pih,     n_pih;
    logic                r_out_valid;
    t_result             r_res,     n_res;

    logic [LVL_IO_W-1:0] eff_step;
    logic signed [13:0]  span;
    logic                start_ok;
    logic [LVL_W-1:0]    start_ext;
    logic [LVL_W-1:0]    amp_ext;
    logic [LVL_W-1:0]    lvl_from;
    logic [LVL_W+1:0]    hi_sum;
    logic [LVL_W-1:0]    hi_lvl;
    logic [LVL_W-1:0]    lo_lvl;
    logic [HOLD_W-1:0]   hold_dec;
    logic [SUM_W-1:0]    sum_acc;
    logic [CNT_W-1:0]    cnt_acc;
    logic [PROD_W-1:0]   avg_prod;
    logic [SMP_W-1:0]    avg;
    logic [CLIMB_W-1:0]  climb_new;
    logic signed [14:0]  climb_chk;
    logic                do_enter;
    logic                ent_high;
    logic [LVL_W-1:0]    ent_lvl;
    logic [HOLD_W-1:0]   ent_hold;
    logic                pv;
    logic                last;
    logic [SMP_W-1:0]    hi_rd;
    logic [SMP_W-1:0]    lo_rd;

    assign o_item_pop  = i_item_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    assign eff_step  = (i_cfg.stair_step == '0) ? LVL_IO_W'(1) : i_cfg.stair_step;
    assign span      = $signed({2'b00, i_cfg.end_level}) - $signed({2'b00, i_cfg.start_level});
    assign start_ok  = $signed({2'b00, eff_step}) <= span;
    assign start_ext = LVL_W'(i_cfg.start_level);
    assign amp_ext   = LVL_W'(i_cfg.pulse_height);

    // high points climb from the start level out of the base hold, else from the low point
    assign lvl_from = (r_phase == PH_SAMPLE) ? r_drive : start_ext;
    assign hi_sum   = {2'b00, lvl_from} + (LVL_W + 2)'(eff_step)
                    + (LVL_W + 2)'(i_cfg.pulse_height);
    assign hi_lvl   = (hi_sum > LVL_CAP) ? LVL_W'(LEVEL_MAX) : hi_sum[LVL_W-1:0];
    assign lo_lvl   = (r_drive > amp_ext) ? (r_drive - amp_ext) : '0;

    assign hold_dec  = (r_hold != '0) ? (r_hold - HOLD_W'(1)) : '0;
    assign sum_acc   = r_sum + SUM_W'(i_item.sample);
    assign cnt_acc   = r_cnt + CNT_W'(1);
    assign avg_prod  = PROD_W'(sum_acc) * PROD_W'(REC_MUL);
    assign avg       = avg_prod[REC_SHIFT +: SMP_W];
    assign climb_new = r_climb + CLIMB_W'(eff_step);
    assign climb_chk = $signed({2'b00, climb_new}) + $signed({3'b000, eff_step});

    always_comb begin
        n_phase   = r_phase;
        n_drive   = r_drive;
        n_hold    = r_hold;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_held_hi = r_held_hi;
        n_climb   = r_climb;
        n_pih     = r_pih;
        do_enter  = 1'b0;
        ent_high  = 1'b1;
        ent_lvl   = hi_lvl;
        pv        = 1'b0;
        last      = 1'b0;
        hi_rd     = '0;
        lo_rd     = '0;

        unique case (i_item.op)
            OP_START: begin
                if (r_phase == PH_IDLE && start_ok) begin
                    n_climb = '0;
                    n_pih   = 1'b1;
                    n_drive = start_ext;
                    n_hold  = i_cfg.base_hold_ms;
                    n_phase = PH_BASE;
                    // zero base hold goes straight to the first high point
                    if (i_cfg.base_hold_ms == '0) begin
                        do_enter = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (r_phase == PH_BASE || r_phase == PH_HOLD) begin
                    n_hold = hold_dec;
                    if (hold_dec == '0) begin
                        if (r_phase == PH_BASE) begin
                            do_enter = 1'b1;
                        end else begin
                            n_phase = PH_SAMPLE;
                        end
                    end
                end
            end
            OP_SAMPLE: begin
                if (r_phase == PH_SAMPLE) begin
                    n_sum = sum_acc;
                    n_cnt = cnt_acc;
                    if (cnt_acc >= CNT_W'(SAMPLES_PER_POINT)) begin
                        if (r_pih) begin
                            n_held_hi = avg;
                            do_enter  = 1'b1;
                            ent_high  = 1'b0;
                            ent_lvl   = lo_lvl;
                        end else begin
                            pv      = 1'b1;
                            hi_rd   = r_held_hi;
                            lo_rd   = avg;
                            n_climb = climb_new;
                            if (climb_chk > $signed({span[13], span})) begin
                                last    = 1'b1;
                                n_phase = PH_IDLE;
                                n_drive = start_ext;
                                n_hold  = '0;
                                n_cnt   = '0;
                                n_sum   = '0;
                                n_pih   = 1'b1;
                            end else begin
                                do_enter = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        ent_hold = ent_high ? i_cfg.high_hold_ms : i_cfg.low_hold_ms;
        if (do_enter) begin
            n_pih   = ent_high;
            n_drive = ent_lvl;
            n_hold  = ent_hold;
            n_cnt   = '0;
            n_sum   = '0;
            n_phase = (ent_hold == '0) ? PH_SAMPLE : PH_HOLD;
        end

        n_res.dac_level      = n_drive[LVL_IO_W-1:0];
        n_res.channel        = i_cfg.channel_select;
        n_res.busy_res       = (n_phase != PH_IDLE);
        n_res.sample_request = (n_phase == PH_SAMPLE);
        n_res.pair_valid     = pv;
        n_res.high_reading   = hi_rd;
        n_res.low_reading    = lo_rd;
        n_res.last_pair      = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_drive     <= '0;
            r_hold      <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_held_hi   <= '0;
            r_climb     <= '0;
            r_pih       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_pop) begin
                r_phase     <= n_phase;
                r_drive     <= n_drive;
                r_hold      <= n_hold;
                r_cnt       <= n_cnt;
                r_sum       <= n_sum;
                r_held_hi   <= n_held_hi;
                r_climb     <= n_climb;
                r_pih       <= n_pih;
                r_res       <= n_res;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/pulse_voltammetry_sequencer.sv @@
// differential pulse voltammetry waveform sequencer
// input channel (i_in_valid / o_in_stall): one item per command, cmd 0 starts a
//   run, cmd 1 is a 1 ms tick, cmd 2 delivers an adc sample in i_sample_value
// output channel (o_out_valid / i_out_stall): exactly one result item per input
//   item, in order, giving the dac code, channel, busy and sample request flags
//   and, at the end of each low point, the averaged high and low readings
// config channel (i_cfg_valid / o_cfg_ready): ready is always high, index 0..7
//   selects the register; write only while no items are in flight
// latency: two cycles from the edge that accepts an item to the first edge its
//   result can be taken, one in the four-entry front queue and one in the
//   sequencer output register
// throughput: one item per cycle, set by the single-cycle sequencer update
//   (one level add with clamp and one reciprocal multiply for the average)
// when the receiver stalls, the output register holds its result, the queue
//   keeps accepting until four items wait, then o_in_stall rises
// synchronous active-low reset empties the queue, drops o_out_valid, returns
//   the sequencer to idle at level 0 and loads the register defaults
`default_nettype none

module pulse_voltammetry_sequencer #(
    parameter int SAMPLES_PER_POINT = 10,
    parameter int LEVEL_MAX         = 4095
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire [pvs_pkg::CMD_W-1:0]       i_cmd,
    input  wire [pvs_pkg::SMP_W-1:0]       i_sample_value,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [pvs_pkg::LVL_IO_W-1:0]   o_dac_level,
    output logic                           o_channel,
    output logic                           o_busy_res,
    output logic                           o_sample_request,
    output logic                           o_pair_valid,
    output logic [pvs_pkg::SMP_W-1:0]      o_high_reading,
    output logic [pvs_pkg::SMP_W-1:0]      o_low_reading,
    output logic                           o_last_pair,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [pvs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [pvs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pvs_pkg::*;

    t_cfg    r_cfg;
    logic    item_valid;
    t_item   item;
    logic    item_pop;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_level     <= RST_START_LEVEL;
            r_cfg.end_level       <= RST_END_LEVEL;
            r_cfg.stair_step      <= RST_STAIR_STEP;
            r_cfg.pulse_height    <= RST_PULSE_AMP;
            r_cfg.base_hold_ms    <= RST_HOLD_MS;
            r_cfg.high_hold_ms    <= RST_HOLD_MS;
            r_cfg.low_hold_ms     <= RST_HOLD_MS;
            r_cfg.channel_select  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_START_LEVEL: r_cfg.start_level     <= i_cfg_data[LVL_IO_W-1:0];
                REG_END_LEVEL:   r_cfg.end_level       <= i_cfg_data[LVL_IO_W-1:0];
                REG_STAIR_STEP:  r_cfg.stair_step      <= i_cfg_data[LVL_IO_W-1:0];
                REG_PULSE_AMP:   r_cfg.pulse_height    <= i_cfg_data[LVL_IO_W-1:0];
                REG_BASE_HOLD:   r_cfg.base_hold_ms    <= i_cfg_data[HOLD_W-1:0];
                REG_HIGH_HOLD:   r_cfg.high_hold_ms    <= i_cfg_data[HOLD_W-1:0];
                REG_LOW_HOLD:    r_cfg.low_hold_ms     <= i_cfg_data[HOLD_W-1:0];
                REG_CHANNEL_SEL: r_cfg.channel_select  <= i_cfg_data[0];
            endcase
        end
    end

    pvs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_cmd          (i_cmd),
        .i_sample_value (i_sample_value),
        .o_in_stall     (o_in_stall),
        .o_item_valid   (item_valid),
        .o_item         (item),
        .i_item_pop     (item_pop)
    );

    pvs_back #(
        .SAMPLES_PER_POINT (SAMPLES_PER_POINT),
        .LEVEL_MAX         (LEVEL_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_res        (res)
    );

    assign o_dac_level      = res.dac_level;
    assign o_channel        = res.channel;
    assign o_busy_res       = res.busy_res;
    assign o_sample_request = res.sample_request;
    assign o_pair_valid     = res.pair_valid;
    assign o_high_reading   = res.high_reading;
    assign o_low_reading    = res.low_reading;
    assign o_last_pair      = res.last_pair;

`ifndef NO_ASSERTIONS
    // readings and the last flag are only carried by a pair result
    a_no_pair_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_pair_valid) |->
        (o_high_reading == '0 && o_low_reading == '0 && !o_last_pair))
        else $error("readings set on a result without a pair");

    // the final pair ends the run back at the start level
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_pair) |->
        (o_pair_valid && !o_busy_res && !o_sample_request &&
         o_dac_level == r_cfg.start_level))
        else $error("last pair without return to idle");

    // sampling only happens inside a run
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sample_request) |-> o_busy_res)
        else $error("sample request while idle");

    // a result is never dropped while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result lost");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

    import pvs_pkg::*;

    localparam int POINT_SAMPLES = 10;
    localparam int DAC_CEILING   = 4095;
    localparam int RUN_LIMIT_NS  = 3_000_000;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_BASE,
        SEQ_HOLD,
        SEQ_SAMPLING
    } t_seq_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd;
    logic [SMP_W-1:0]      i_sample_value;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [LVL_IO_W-1:0]   o_dac_level;
    logic                  o_channel;
    logic                  o_busy_res;
    logic                  o_sample_request;
    logic                  o_pair_valid;
    logic [SMP_W-1:0]      o_high_reading;
    logic [SMP_W-1:0]      o_low_reading;
    logic                  o_last_pair;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pulse_voltammetry_sequencer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_sample_value   (i_sample_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_dac_level      (o_dac_level),
        .o_channel        (o_channel),
        .o_busy_res       (o_busy_res),
        .o_sample_request (o_sample_request),
        .o_pair_valid     (o_pair_valid),
        .o_high_reading   (o_high_reading),
        .o_low_reading    (o_low_reading),
        .o_last_pair      (o_last_pair),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // waveform model state
    t_cfg          cfg_model;
    t_seq_phase    seq_phase;
    logic [11:0]   dac_model;
    logic [15:0]   hold_left;
    logic [3:0]    nsamp;
    logic [15:0]   acc;
    logic [11:0]   held_high;
    logic [12:0]   climbed;
    logic          at_high;

    t_result       predicted_outputs[$];
    t_result       want_out;

    int mismatches     = 0;
    int items_sent     = 0;
    int random_items   = 0;
    int pairs_done     = 0;
    int runs_started   = 0;
    int reg_writes     = 0;
    int tx_gap_max     = 0;
    int rx_gap_max     = 0;
    int out_stall_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic void reset_model();
        cfg_model.start_level     = RST_START_LEVEL;
        cfg_model.end_level       = RST_END_LEVEL;
        cfg_model.stair_step      = RST_STAIR_STEP;
        cfg_model.pulse_height    = RST_PULSE_AMP;
        cfg_model.base_hold_ms    = RST_HOLD_MS;
        cfg_model.high_hold_ms    = RST_HOLD_MS;
        cfg_model.low_hold_ms     = RST_HOLD_MS;
        cfg_model.channel_select  = 1'b0;
        seq_phase = SEQ_IDLE;
        dac_model = '0;
        hold_left = '0;
        nsamp     = '0;
        acc       = '0;
        held_high = '0;
        climbed   = '0;
        at_high   = 1'b1;
    endfunction

    function automatic int step_size();
        return (cfg_model.stair_step == 0) ? 1 : int'(cfg_model.stair_step);
    endfunction

    function automatic void enter_point(input logic [11:0] lvl);
        dac_model = lvl;
        hold_left = at_high ? cfg_model.high_hold_ms : cfg_model.low_hold_ms;
        nsamp     = '0;
        acc       = '0;
        seq_phase = (hold_left == 0) ? SEQ_SAMPLING : SEQ_HOLD;
    endfunction

    function automatic void enter_high(input logic [11:0] from);
        int lvl;
        lvl = int'(from) + step_size() + int'(cfg_model.pulse_height);
        if (lvl > DAC_CEILING) begin
            lvl = DAC_CEILING;
        end
        at_high = 1'b1;
        enter_point(12'(lvl));
    endfunction

    // works out the output item for one accepted input item
    function automatic void advance_waveform(input t_op op, input logic [11:0] smp);
        t_result     r;
        int          span;
        logic [11:0] avg;
        r    = '0;
        span = int'(cfg_model.end_level) - int'(cfg_model.start_level);
        case (op)
            OP_START: begin
                if (seq_phase == SEQ_IDLE && step_size() <= span) begin
                    runs_started++;
                    climbed   = '0;
                    at_high   = 1'b1;
                    dac_model = cfg_model.start_level;
                    hold_left = cfg_model.base_hold_ms;
                    seq_phase = SEQ_BASE;
                    if (hold_left == 0) begin
                        enter_high(cfg_model.start_level);
                    end
                end
            end
            OP_TICK: begin
                if (seq_phase == SEQ_BASE || seq_phase == SEQ_HOLD) begin
                    if (hold_left != 0) begin
                        hold_left = hold_left - 1'b1;
                    end
                    if (hold_left == 0) begin
                        if (seq_phase == SEQ_BASE) begin
                            enter_high(cfg_model.start_level);
                        end else begin
                            seq_phase = SEQ_SAMPLING;
                        end
                    end
                end
            end
            OP_SAMPLE: begin
                if (seq_phase == SEQ_SAMPLING) begin
                    acc   = acc + 16'(smp);
                    nsamp = nsamp + 1'b1;
                    if (nsamp >= POINT_SAMPLES) begin
                        avg = 12'(acc / POINT_SAMPLES);
                        if (at_high) begin
                            held_high = avg;
                            at_high   = 1'b0;
                            enter_point(dac_model > cfg_model.pulse_height ?
                                        dac_model - cfg_model.pulse_height : 12'd0);
                        end else begin
                            pairs_done++;
                            r.pair_valid   = 1'b1;
                            r.high_reading = held_high;
                            r.low_reading  = avg;
                            climbed = climbed + 13'(step_size());
                            if (int'(climbed) + step_size() > span) begin
                                r.last_pair = 1'b1;
                                seq_phase   = SEQ_IDLE;
                                dac_model   = cfg_model.start_level;
                                hold_left   = '0;
                                nsamp       = '0;
                                acc         = '0;
                                at_high     = 1'b1;
                            end else begin
                                enter_high(dac_model);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.dac_level      = dac_model;
        r.channel        = cfg_model.channel_select;
        r.busy_res       = (seq_phase != SEQ_IDLE);
        r.sample_request = (seq_phase == SEQ_SAMPLING);
        predicted_outputs.push_back(r);
    endfunction

    task automatic push_command(input t_op op, input logic [11:0] smp);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_cmd          <= op;
        i_sample_value <= smp;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        advance_waveform(op, smp);
    endtask

    // stop sending and let every predicted item come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            REG_START_LEVEL: cfg_model.start_level     = val[11:0];
            REG_END_LEVEL:   cfg_model.end_level       = val[11:0];
            REG_STAIR_STEP:  cfg_model.stair_step      = val[11:0];
            REG_PULSE_AMP:   cfg_model.pulse_height    = val[11:0];
            REG_BASE_HOLD:   cfg_model.base_hold_ms    = val;
            REG_HIGH_HOLD:   cfg_model.high_hold_ms    = val;
            REG_LOW_HOLD:    cfg_model.low_hold_ms     = val;
            REG_CHANNEL_SEL: cfg_model.channel_select  = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_gap();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 16;
        endcase
    endfunction

    function automatic logic [15:0] short_hold();
        return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 12))
                                           : 16'($urandom_range(0, 3));
    endfunction

    // receiver stall: drawn after each accepted result, applied from the next falling edge
    always @(negedge i_clk) begin
        if (out_stall_left > 0) begin
            i_out_stall <= 1'b1;
            out_stall_left = out_stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_outputs.size() == 0) begin
                flag_mismatch("result item with nothing predicted", o_dac_level, 0);
            end else begin
                want_out = predicted_outputs.pop_front();
                if (o_dac_level !== want_out.dac_level)
                    flag_mismatch("dac_level", o_dac_level, want_out.dac_level);
                if (o_channel !== want_out.channel)
                    flag_mismatch("channel", o_channel, want_out.channel);
                if (o_busy_res !== want_out.busy_res)
                    flag_mismatch("busy_res", o_busy_res, want_out.busy_res);
                if (o_sample_request !== want_out.sample_request)
                    flag_mismatch("sample_request", o_sample_request, want_out.sample_request);
                if (o_pair_valid !== want_out.pair_valid)
                    flag_mismatch("pair_valid", o_pair_valid, want_out.pair_valid);
                if (o_high_reading !== want_out.high_reading)
                    flag_mismatch("high_reading", o_high_reading, want_out.high_reading);
                if (o_low_reading !== want_out.low_reading)
                    flag_mismatch("low_reading", o_low_reading, want_out.low_reading);
                if (o_last_pair !== want_out.last_pair)
                    flag_mismatch("last_pair", o_last_pair, want_out.last_pair);
            end
            out_stall_left = $urandom_range(0, rx_gap_max);
        end
    end

    // nothing is running after reset, so every command but start is ignored
    task automatic test_idle_commands();
        tx_gap_max = 16;
        rx_gap_max = 16;
        push_command(OP_TICK, 12'd0);
        push_command(OP_NONE, '1);
        push_command(OP_SAMPLE, '1);
    endtask

    // span shorter than one step, reversed span included: start has no effect
    task automatic test_empty_runs();
        tx_gap_max = 0;
        rx_gap_max = 0;
        wait_drained();
        write_reg(REG_START_LEVEL, 16'hFFFF);
        write_reg(REG_END_LEVEL, 16'h0000);
        write_reg(REG_BASE_HOLD, 16'hFFFF);
        write_reg(REG_HIGH_HOLD, 16'hFFFF);
        write_reg(REG_LOW_HOLD, 16'hFFFF);
        push_command(OP_START, 12'd0);
        wait_drained();
        write_reg(REG_START_LEVEL, 16'h0000);
        write_reg(REG_END_LEVEL, 16'h0FFE);
        write_reg(REG_STAIR_STEP, 16'h0FFF);
        push_command(OP_START, 12'd0);
    endtask

    // zero step and holds, full-scale pulse: high point clamps to the ceiling,
    // low point to zero; span is cut mid-run so the first pair is the last
    task automatic test_clamped_pair();
        tx_gap_max = 4;
        rx_gap_max = 16;
        wait_drained();
        write_reg(REG_END_LEVEL, 16'h0FFF);
        write_reg(REG_STAIR_STEP, 16'h0000);
        write_reg(REG_PULSE_AMP, 16'h0FFF);
        write_reg(REG_BASE_HOLD, 16'h0000);
        write_reg(REG_HIGH_HOLD, 16'h0000);
        write_reg(REG_LOW_HOLD, 16'h0000);
        write_reg(REG_CHANNEL_SEL, 16'h0001);
        push_command(OP_START, '1);
        push_command(OP_START, 12'd0);
        repeat (POINT_SAMPLES) push_command(OP_SAMPLE, '1);
        wait_drained();
        write_reg(REG_END_LEVEL, 16'h0001);
        write_reg(REG_HIGH_HOLD, 16'hFFFF);
        repeat (POINT_SAMPLES) push_command(OP_SAMPLE, 12'd0);
    endtask

    // well-formed runs with random content under random settings, mixed with
    // stray commands and the odd register change between items of a run
    task automatic test_random_runs();
        int                   eff;
        int                   end_i;
        int                   guard;
        logic [11:0]          lvl;
        logic [11:0]          v;
        logic [CFG_IDX_W-1:0] idx;
        while (random_items < 560) begin
            wait_drained();
            tx_gap_max = pick_gap();
            rx_gap_max = pick_gap();
            lvl = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(3000, 4095))
                                              : 12'($urandom_range(0, 3000));
            write_reg(REG_START_LEVEL, {4'($urandom), lvl});
            v = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
            write_reg(REG_STAIR_STEP, {4'($urandom), v});
            eff = (v == 0) ? 1 : int'(v);
            if ($urandom_range(0, 7) == 0) begin
                end_i = $urandom_range(0, 4095);
            end else begin
                end_i = int'(lvl) + eff * $urandom_range(1, 5) + $urandom_range(0, eff - 1);
            end
            if (end_i > DAC_CEILING) begin
                end_i = DAC_CEILING;
            end
            write_reg(REG_END_LEVEL, {4'($urandom), 12'(end_i)});
            v = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 100));
            write_reg(REG_PULSE_AMP, {4'($urandom), v});
            write_reg(REG_BASE_HOLD, short_hold());
            write_reg(REG_HIGH_HOLD, short_hold());
            write_reg(REG_LOW_HOLD, short_hold());
            write_reg(REG_CHANNEL_SEL, 16'($urandom));
            repeat ($urandom_range(1, 3)) begin
                push_command(OP_START, 12'($urandom));
                guard = 0;
                while (seq_phase != SEQ_IDLE && guard < 4000) begin
                    guard++;
                    if ($urandom_range(0, 149) == 0) begin
                        wait_drained();
                        idx = CFG_IDX_W'($urandom_range(0, 7));
                        if (idx == REG_BASE_HOLD || idx == REG_HIGH_HOLD ||
                            idx == REG_LOW_HOLD) begin
                            write_reg(idx, 16'($urandom_range(0, 5)));
                        end else begin
                            write_reg(idx, 16'($urandom));
                        end
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        push_command(t_op'($urandom_range(0, 3)), 12'($urandom));
                    end else if (seq_phase == SEQ_SAMPLING) begin
                        random_items++;
                        if ($urandom_range(0, 15) == 0) begin
                            v = '1;
                        end else if ($urandom_range(0, 15) == 0) begin
                            v = '0;
                        end else begin
                            v = 12'($urandom);
                        end
                        push_command(OP_SAMPLE, v);
                    end else begin
                        random_items++;
                        push_command(OP_TICK, 12'($urandom));
                    end
                end
            end
        end
    endtask

    initial begin
        reset_model();
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_cmd          <= OP_START;
        i_sample_value <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_START_LEVEL;
        i_cfg_data     <= '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_empty_runs();
        test_clamped_pair();
        test_random_runs();

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d items over %0d runs with %0d register writes",
                 items_sent, runs_started, reg_writes);
        $display("checked %0d high/low reading pairs, %0d mismatches",
                 pairs_done, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pvs_pkg.sv
rtl/pvs_front.sv
rtl/pvs_back.sv
rtl/pulse_voltammetry_sequencer.sv
tb/tb.sv
